[design/bpp_pkg.sv]
// Shared types and constants for the buzzer pattern player.
// Used by bpp_channel, buzzer_pattern_player_unit and the verification files; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int PAT_BITS     = 32;
  localparam int POS_W        = $clog2(PAT_BITS + 1);
  localparam int IDX_W        = $clog2(PAT_BITS);
  localparam int OUT_W        = 4;
  localparam int CFG_W        = 3;
  localparam int REP_W        = 8;
  localparam int IN_PAT_W     = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } opcode_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [1:0]            channel;
    logic [IN_PAT_W-1:0]   pattern;
    logic [REP_W-1:0]      repeat_count;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] buzz_levels;
    logic [OUT_W-1:0] busy_mask;
    logic             rejected;
  } out_item_t;

  // Per-channel command for the transfer that moves to the result register
  typedef struct packed {
    logic                advance;
    logic                load;
    logic                clear;
    logic [PAT_BITS-1:0] pattern;
    logic [REP_W-1:0]    repeats;
  } chan_cmd_t;

  // Channel status after the update
  typedef struct packed {
    logic level;
    logic busy;
  } chan_stat_t;

endpackage

`default_nettype wire

[design/bpp_channel.sv]
// One buzzer channel: pattern, bit position, repeat count and drive level.
// Depends on bpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpp_channel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpp_pkg::chan_cmd_t  cmd_i,
  output bpp_pkg::chan_stat_t stat_o
);
  import bpp_pkg::*;

  logic [PAT_BITS-1:0] pattern_q, pattern_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [REP_W-1:0]    rep_q, rep_d;
  logic                drive_q, drive_d;

  logic [POS_W-1:0]    pos_inc;
  logic [IDX_W-1:0]    bit_idx;
  logic [REP_W-1:0]    rep_dec;

  always_comb begin
    pattern_d = pattern_q;
    pos_d     = pos_q;
    rep_d     = rep_q;
    drive_d   = drive_q;
    pos_inc   = pos_q + 1'b1;
    bit_idx   = IDX_W'(POS_W'(PAT_BITS) - pos_inc);
    rep_dec   = rep_q - 1'b1;
    priority if (cmd_i.clear) begin
      // stop keeps the bit position
      drive_d   = 1'b0;
      pattern_d = '0;
      rep_d     = '0;
    end else if (cmd_i.load) begin
      pattern_d = cmd_i.pattern;
      rep_d     = cmd_i.repeats;
    end else if (cmd_i.advance && (pattern_q != '0)) begin
      if (pos_q >= POS_W'(PAT_BITS)) begin
        // gap tick after the last bit; count zero wraps around
        drive_d = 1'b0;
        pos_d   = '0;
        rep_d   = rep_dec;
        if (rep_dec == '0) begin
          pattern_d = '0;
        end
      end else begin
        pos_d   = pos_inc;
        drive_d = pattern_q[bit_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      pos_q     <= '0;
      rep_q     <= '0;
      drive_q   <= 1'b0;
    end else begin
      pattern_q <= pattern_d;
      pos_q     <= pos_d;
      rep_q     <= rep_d;
      drive_q   <= drive_d;
    end
  end

  assign stat_o.level = drive_d;
  assign stat_o.busy  = |pattern_d;

endmodule

`default_nettype wire

[design/buzzer_pattern_player_unit.sv]
// Top level of the buzzer pattern player: input register, channel array,
// result register and the channel-count register. Depends on bpp_pkg, bpp_channel.
//
//  port group   dir  handshake            payload
//  in_*         in   in_valid_i/in_stall_o   bpp_pkg::in_item_t
//  out_*        out  out_valid_o/out_stall_i bpp_pkg::out_item_t
//  cfg_*        in   cfg_valid_i/cfg_ready_o channels in use, 3 bits
//
// One item per cycle sustained while the result register is not stalled; each item
// goes from the input register to the result register, all channels updating in parallel as it moves.
// The result register holds under out_stall_i; the input register keeps taking
// items while the result register is free or being drained in the same cycle.
// Reset clears all channel state and the channel count; no clearing pass.
// cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_pattern_player_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bpp_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bpp_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bpp_pkg::CFG_W-1:0]    cfg_data_i
);
  import bpp_pkg::*;

  in_item_t   in_q;
  logic       in_vld_q;
  out_item_t  out_q, out_d;
  logic       out_vld_q;
  logic [CFG_W-1:0] cfg_q;

  logic       move_w;
  logic       is_cmd;
  logic       ch_ok;

  chan_cmd_t               cmd_w   [NUM_CHANNELS];
  chan_stat_t              stat_w  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] level_w;
  logic [NUM_CHANNELS-1:0] busy_w;

  assign move_w      = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !move_w;
  assign cfg_ready_o = 1'b1;

  assign is_cmd = (in_q.opcode == OP_START) || (in_q.opcode == OP_STOP);
  assign ch_ok  = ({1'b0, in_q.channel} < cfg_q) && (32'(in_q.channel) < NUM_CHANNELS);

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    logic hit;
    assign hit = move_w && ch_ok && (32'(in_q.channel) == c);

    always_comb begin
      cmd_w[c].advance = move_w && (in_q.opcode == OP_TICK) && (32'(cfg_q) > c);
      cmd_w[c].load    = hit && (in_q.opcode == OP_START);
      cmd_w[c].clear   = hit && (in_q.opcode == OP_STOP);
      cmd_w[c].pattern = PAT_BITS'(in_q.pattern);
      cmd_w[c].repeats = in_q.repeat_count;
    end

    bpp_channel u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_w[c]),
      .stat_o (stat_w[c])
    );

    assign level_w[c] = stat_w[c].level;
    assign busy_w[c]  = stat_w[c].busy;
  end

  always_comb begin
    out_d.buzz_levels = OUT_W'(level_w);
    out_d.busy_mask   = OUT_W'(busy_w);
    out_d.rejected    = is_cmd && !ch_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cfg_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (move_w) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (move_w) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // a tick never reports a rejection
  a_tick_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_w && (in_q.opcode == OP_TICK) |=> out_vld_q && !out_q.rejected)
    else $error("tick produced a rejected result");

  // with no channels in use every start or stop is rejected
  a_zero_cfg_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_w && (cfg_q == '0) && is_cmd |=> out_q.rejected)
    else $error("command accepted with no channels in use");

  // input side stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without a blocked result");

  // an item leaving the input register always produces a result next cycle
  a_move_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_w |=> out_vld_q)
    else $error("transfer to result register lost");

endmodule

`default_nettype wire

[verif/bpp_playback_checker.sv]
// Checker for the buzzer pattern player: watches input, result and config transfers,
// predicts each result from its own copy of the channel state and compares.
// Depends on bpp_pkg.
`timescale 1ns / 1ps

module bpp_playback_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  bpp_pkg::in_item_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  bpp_pkg::out_item_t        out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [bpp_pkg::CFG_W-1:0] cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  import bpp_pkg::*;

  logic [PAT_BITS-1:0] pattern_q [NUM_CHANNELS];
  logic [5:0]          position_q [NUM_CHANNELS];
  logic [REP_W-1:0]    repeats_q [NUM_CHANNELS];
  logic                level_q [NUM_CHANNELS];
  logic [CFG_W-1:0]    chans_in_use_q;
  out_item_t           expected_levels_q [$];

  task automatic note_mismatch(input string what, input int got, input int want);
    fail_count_o++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // One tick for one channel: next bit MSB first, then one low tick per pass end.
  task automatic tick_channel(input int c);
    if (pattern_q[c] == '0) return;
    if (position_q[c] >= PAT_BITS) begin
      level_q[c]    = 1'b0;
      position_q[c] = '0;
      repeats_q[c]  = repeats_q[c] - 1'b1;
      if (repeats_q[c] == '0) pattern_q[c] = '0;
    end else begin
      position_q[c] = position_q[c] + 1'b1;
      level_q[c]    = pattern_q[c][PAT_BITS - position_q[c]];
    end
  endtask

  task automatic play_item(input in_item_t it);
    int        active;
    out_item_t want;
    active = (chans_in_use_q > NUM_CHANNELS) ? NUM_CHANNELS : int'(chans_in_use_q);
    want   = '0;
    case (it.opcode)
      OP_TICK: begin
        for (int c = 0; c < active; c++) tick_channel(c);
      end
      OP_START, OP_STOP: begin
        if (int'(it.channel) >= active) begin
          want.rejected = 1'b1;
        end else if (it.opcode == OP_START) begin
          pattern_q[it.channel] = it.pattern;
          repeats_q[it.channel] = it.repeat_count;
        end else begin
          level_q[it.channel]   = 1'b0;
          pattern_q[it.channel] = '0;
          repeats_q[it.channel] = '0;
        end
      end
      default: ;
    endcase
    for (int c = 0; c < OUT_W; c++) begin
      want.buzz_levels[c] = level_q[c];
      want.busy_mask[c]   = (pattern_q[c] != '0);
    end
    expected_levels_q = {expected_levels_q, want};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pattern_q[c]  = '0;
        position_q[c] = '0;
        repeats_q[c]  = '0;
        level_q[c]    = 1'b0;
      end
      chans_in_use_q = '0;
      expected_levels_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_levels_q.size() == 0) begin
          note_mismatch("result with nothing expected", int'(out_data_i), 0);
        end else begin
          want = expected_levels_q.pop_front();
          if (out_data_i.buzz_levels !== want.buzz_levels)
            note_mismatch("buzz_levels", out_data_i.buzz_levels, want.buzz_levels);
          if (out_data_i.busy_mask !== want.busy_mask)
            note_mismatch("busy_mask", out_data_i.busy_mask, want.busy_mask);
          if (out_data_i.rejected !== want.rejected)
            note_mismatch("rejected", out_data_i.rejected, want.rejected);
        end
      end
      if (in_valid_i && !in_stall_i) play_item(in_data_i);
      if (cfg_valid_i && cfg_ready_i) chans_in_use_q = cfg_data_i;
      pending_o = expected_levels_q.size();
    end
  end

endmodule

[verif/tb_buzzer_pattern_player_unit.sv]
// Testbench top for buzzer_pattern_player_unit: clock, reset, stimulus and verdict.
// Depends on bpp_pkg, buzzer_pattern_player_unit and bpp_playback_checker.
`timescale 1ns / 1ps

module tb_buzzer_pattern_player_unit;
  import bpp_pkg::*;

  // opcode with no defined operation
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int fails;
  int pending;
  int tx_idle_pct;
  int rx_stall_pct;
  int results_seen;
  int hold_left;
  bit held_once;

  int chan_count_seq [8] = '{4, 7, 2, 0, 1, 3, 4, 5};

  buzzer_pattern_player_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  bpp_playback_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall, plus one long hold-off so the block backs up.
  // The hold starts mid second phase, while the sender is still offering items.
  initial begin
    out_stall    = 1'b0;
    results_seen = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) results_seen++;
      @(negedge clk);
      if (!held_once && results_seen >= 300) begin
        held_once = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  function automatic in_item_t make_item(input logic [1:0] op, input logic [1:0] ch,
                                         input logic [31:0] pat, input logic [7:0] rep);
    in_item_t it;
    it.opcode       = opcode_e'(op);
    it.channel      = ch;
    it.pattern      = pat;
    it.repeat_count = rep;
    return it;
  endfunction

  function automatic logic [31:0] rand_pattern();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    if (r < 30) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic logic [7:0] rand_repeats();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'd1;
    if (r < 60) return 8'd2;
    if (r < 70) return 8'd0;
    if (r < 75) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Entered and left at a falling edge.
  task automatic send_item(input in_item_t it);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_chan_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int budget;
    int sent;
    int burst;
    int mode;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // channel count still zero after reset: commands are refused
    send_item(make_item(OP_START, 2'd0, 32'hFFFF_FFFF, 8'd1));
    send_item(make_item(OP_TICK, 2'd3, 32'hFFFF_FFFF, 8'hFF));

    write_chan_count(3'd4);
    send_item(make_item(OP_START, 2'd0, 32'hFFFF_FFFF, 8'd255));
    send_item(make_item(OP_START, 2'd1, 32'h8000_0001, 8'd0));
    send_item(make_item(OP_START, 2'd2, 32'h0000_0000, 8'd5));
    send_item(make_item(OP_START, 2'd3, 32'hA5A5_A5A5, 8'd1));
    repeat (4) send_item(make_item(OP_TICK, 2'd0, '0, '0));
    send_item(make_item(OP_UNUSED, 2'd3, 32'hFFFF_FFFF, 8'hFF));
    // restart mid-pattern: position carries on
    send_item(make_item(OP_START, 2'd3, 32'h0000_0001, 8'd2));
    send_item(make_item(OP_STOP, 2'd1, 32'hFFFF_FFFF, 8'hFF));
    repeat (2) send_item(make_item(OP_TICK, 2'd0, '0, '0));
    send_item(make_item(OP_START, 2'd1, 32'h8000_0000, 8'd1));
    repeat (2) send_item(make_item(OP_TICK, 2'd0, '0, '0));

    for (int p = 0; p < 8; p++) begin
      write_chan_count(chan_count_seq[p][CFG_W-1:0]);
      mode         = p % 4;
      tx_idle_pct  = (mode == 1) ? 51 : (mode == 3) ? 38 : 0;
      rx_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 38 : 0;
      budget       = (chan_count_seq[p] == 0) ? 40 : 185;
      sent         = 0;
      // bursts: load a channel, then mostly ticks with some stray commands
      while (sent < budget) begin
        send_item(make_item(OP_START, 2'($urandom_range(0, 3)), rand_pattern(),
                            rand_repeats()));
        sent++;
        burst = $urandom_range(1, 80);
        repeat (burst) begin
          if ($urandom_range(0, 99) < 8) begin
            send_item(make_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                rand_pattern(), 8'($urandom_range(0, 255))));
          end else begin
            send_item(make_item(OP_TICK, 2'($urandom_range(0, 3)), $urandom,
                                8'($urandom_range(0, 255))));
          end
          sent++;
        end
      end
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
